/* hdl/bmpd_pkg.sv */
// bmpd_pkg: shared constants and codes of the bmp pixel stream decoder
// depends on nothing; used by the interfaces and every module of the block

package bmpd_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // power of two
    localparam int QUEUE_DEPTH = 4;

    localparam int KIND_W    = 2;
    localparam int ERR_W     = 3;
    localparam int ADDR_W    = 24;
    localparam int COLOR_W   = 24;
    localparam int DIM_OUT_W = 13;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] DEPTH_24      = 16'd24;
    localparam logic [15:0] DEPTH_32      = 16'd32;
    localparam logic [31:0] HEADER_LEN    = 32'd54;
    localparam logic [31:0] HEADER_LAST   = 32'd53;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_SHORT      = 3'd1,
        ERR_SIGNATURE  = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_COMPRESSED = 3'd4,
        ERR_DIMENSIONS = 3'd5,
        ERR_OFFSET     = 3'd6,
        ERR_TRUNCATED  = 3'd7
    } t_err;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_ERROR  = 5'b10000
    } t_phase;

endpackage

/* hdl/bmpd_if.sv */
// bmpd interfaces: byte input channel, result output channel and the
// internal command channel between parser, queue and output stage
// depends on bmpd_pkg

interface bmpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface bmpd_result_if;
    logic                           valid;
    logic                           ready;
    logic [bmpd_pkg::KIND_W-1:0]    result_kind;
    logic [bmpd_pkg::ERR_W-1:0]     error_code;
    logic [bmpd_pkg::ADDR_W-1:0]    pixel_address;
    logic [bmpd_pkg::COLOR_W-1:0]   pixel_color;
    logic [bmpd_pkg::DIM_OUT_W-1:0] image_width;
    logic [bmpd_pkg::DIM_OUT_W-1:0] image_height;
    logic                           last_of_file;

    modport source (output valid, result_kind, error_code, pixel_address, pixel_color,
                    image_width, image_height, last_of_file, input ready);
    modport sink   (input valid, result_kind, error_code, pixel_address, pixel_color,
                    image_width, image_height, last_of_file, output ready);
endinterface

interface bmpd_cmd_if #(
    parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic                         valid;
    logic                         ready;
    logic [bmpd_pkg::KIND_W-1:0]  kind;
    logic [bmpd_pkg::ERR_W-1:0]   err;
    logic [HW-1:0]                dst_y;
    logic [WW-1:0]                col;
    logic [bmpd_pkg::COLOR_W-1:0] color;
    logic [WW-1:0]                width;
    logic [HW-1:0]                height;
    logic                         last;

    modport source (output valid, kind, err, dst_y, col, color, width, height, last,
                     input ready);
    modport sink   (input valid, kind, err, dst_y, col, color, width, height, last,
                     output ready);
endinterface

/* hdl/bmpd_front.sv */
// bmpd_front: takes file bytes, parses and checks the headers, walks the
// pixel rows and pushes one command per result into the queue
// depends on bmpd_pkg and bmpd_if

module bmpd_front #(
    parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmpd_byte_if.sink   i_byte,
    bmpd_cmd_if.source  o_cmd
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    bmpd_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [31:0]      r_pos, n_pos, cur_pos;
    logic [WW-1:0]    r_col, n_col;
    logic [1:0]       r_idx, n_idx;
    logic [1:0]       r_pad_cnt, n_pad_cnt;
    logic [HW-1:0]    r_row, n_row;

    // raw header fields
    logic [15:0] r_sig;
    logic [31:0] r_offset;
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic [15:0] r_depth;
    logic [31:0] r_comp;

    // precomputed header checks
    logic [31:0]      r_hgt_abs;
    logic             r_bottom_hdr;
    bmpd_pkg::t_err   r_chk_err;

    // accepted image geometry
    logic [WW-1:0] r_wid, r_wid_m1;
    logic [HW-1:0] r_hgt_m1;
    logic          r_bottom;
    logic          r_is32;
    logic [1:0]    r_pad;
    logic [23:0]   r_color;

    logic          acc;
    logic          hdr_grab;
    logic          load_hdr;
    logic          color_wr;
    logic          in_data;
    logic          complete;
    logic          is_final;
    logic          row_end;
    logic [1:0]    bpp_m1;
    logic [HW-1:0] dst_y;
    logic [23:0]   px_color;

    assign acc          = i_byte.valid & i_byte.ready;
    assign i_byte.ready = o_cmd.ready;

    assign cur_phase = i_byte.first_byte ? bmpd_pkg::PH_HEADER : r_phase;
    assign cur_pos   = i_byte.first_byte ? 32'd0 : r_pos;
    assign hdr_grab  = acc && (cur_phase == bmpd_pkg::PH_HEADER) && (cur_pos[31:6] == '0);

    assign bpp_m1   = r_is32 ? 2'd3 : 2'd2;
    assign in_data  = (r_col != r_wid);
    assign complete = in_data && (r_idx == bpp_m1);
    assign is_final = complete && (r_col == r_wid_m1) && (r_row == r_hgt_m1);
    assign row_end  = in_data ? (complete && (r_col == r_wid_m1) && (r_pad == 2'd0))
                              : (2'(r_pad_cnt + 2'd1) == r_pad);
    assign dst_y    = r_bottom ? HW'(r_hgt_m1 - r_row) : r_row;
    assign px_color = r_is32 ? r_color : {i_byte.data_byte, r_color[15:0]};
    assign color_wr = acc && (cur_phase == bmpd_pkg::PH_PIXEL) && in_data && (r_idx != 2'd3);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_col     = r_col;
        n_idx     = r_idx;
        n_pad_cnt = r_pad_cnt;
        n_row     = r_row;
        load_hdr  = 1'b0;

        o_cmd.valid  = 1'b0;
        o_cmd.kind   = bmpd_pkg::KIND_ERROR;
        o_cmd.err    = bmpd_pkg::ERR_NONE;
        o_cmd.dst_y  = '0;
        o_cmd.col    = '0;
        o_cmd.color  = '0;
        o_cmd.width  = '0;
        o_cmd.height = '0;
        o_cmd.last   = 1'b0;

        if (acc) begin
            n_phase = cur_phase;
            n_pos   = (cur_pos == '1) ? cur_pos : cur_pos + 32'd1;
            unique case (cur_phase)
                bmpd_pkg::PH_HEADER: begin
                    if (cur_pos < bmpd_pkg::HEADER_LAST) begin
                        if (i_byte.last_byte) begin
                            o_cmd.valid = 1'b1;
                            o_cmd.err   = bmpd_pkg::ERR_SHORT;
                            o_cmd.last  = 1'b1;
                            n_phase     = bmpd_pkg::PH_ERROR;
                        end
                    end else if (r_chk_err != bmpd_pkg::ERR_NONE) begin
                        o_cmd.valid = 1'b1;
                        o_cmd.err   = r_chk_err;
                        o_cmd.last  = 1'b1;
                        n_phase     = bmpd_pkg::PH_ERROR;
                    end else if (i_byte.last_byte) begin
                        o_cmd.valid = 1'b1;
                        o_cmd.err   = bmpd_pkg::ERR_TRUNCATED;
                        o_cmd.last  = 1'b1;
                        n_phase     = bmpd_pkg::PH_ERROR;
                    end else begin
                        load_hdr     = 1'b1;
                        n_col        = '0;
                        n_idx        = '0;
                        n_pad_cnt    = '0;
                        n_row        = '0;
                        n_phase      = (r_offset == bmpd_pkg::HEADER_LEN) ?
                                       bmpd_pkg::PH_PIXEL : bmpd_pkg::PH_SKIP;
                        o_cmd.valid  = 1'b1;
                        o_cmd.kind   = bmpd_pkg::KIND_HEADER;
                        o_cmd.width  = r_width[WW-1:0];
                        o_cmd.height = r_hgt_abs[HW-1:0];
                    end
                end
                bmpd_pkg::PH_SKIP: begin
                    if (i_byte.last_byte) begin
                        o_cmd.valid = 1'b1;
                        o_cmd.err   = bmpd_pkg::ERR_TRUNCATED;
                        o_cmd.last  = 1'b1;
                        n_phase     = bmpd_pkg::PH_ERROR;
                    end else if (32'(cur_pos + 32'd1) >= r_offset) begin
                        n_phase = bmpd_pkg::PH_PIXEL;
                    end
                end
                bmpd_pkg::PH_PIXEL: begin
                    if (in_data) begin
                        if (complete) begin
                            n_idx = '0;
                            n_col = WW'(r_col + 1'b1);
                        end else begin
                            n_idx = 2'(r_idx + 2'd1);
                        end
                    end else begin
                        n_pad_cnt = 2'(r_pad_cnt + 2'd1);
                    end
                    if (row_end) begin
                        n_col     = '0;
                        n_idx     = '0;
                        n_pad_cnt = '0;
                        n_row     = HW'(r_row + 1'b1);
                    end
                    if (is_final || (complete && !i_byte.last_byte)) begin
                        o_cmd.valid  = 1'b1;
                        o_cmd.kind   = bmpd_pkg::KIND_PIXEL;
                        o_cmd.dst_y  = dst_y;
                        o_cmd.col    = r_col;
                        o_cmd.color  = px_color;
                        o_cmd.width  = r_wid;
                        o_cmd.height = HW'(r_hgt_m1 + 1'b1);
                        o_cmd.last   = is_final;
                        if (is_final) begin
                            n_phase = bmpd_pkg::PH_DONE;
                        end
                    end else if (i_byte.last_byte) begin
                        o_cmd.valid = 1'b1;
                        o_cmd.err   = bmpd_pkg::ERR_TRUNCATED;
                        o_cmd.last  = 1'b1;
                        n_phase     = bmpd_pkg::PH_ERROR;
                    end
                end
                bmpd_pkg::PH_DONE, bmpd_pkg::PH_ERROR: begin
                    n_phase = cur_phase;
                end
                default: begin
                    n_phase = bmpd_pkg::PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bmpd_pkg::PH_HEADER;
            r_pos     <= '0;
            r_col     <= '0;
            r_idx     <= '0;
            r_pad_cnt <= '0;
            r_row     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_col     <= n_col;
            r_idx     <= n_idx;
            r_pad_cnt <= n_pad_cnt;
            r_row     <= n_row;
        end
    end

    // header field capture, little-endian
    always_ff @(posedge i_clk) begin
        if (hdr_grab) begin
            unique case (cur_pos[5:0])
                6'd0:    r_sig[7:0]       <= i_byte.data_byte;
                6'd1:    r_sig[15:8]      <= i_byte.data_byte;
                6'd10:   r_offset[7:0]    <= i_byte.data_byte;
                6'd11:   r_offset[15:8]   <= i_byte.data_byte;
                6'd12:   r_offset[23:16]  <= i_byte.data_byte;
                6'd13:   r_offset[31:24]  <= i_byte.data_byte;
                6'd18:   r_width[7:0]     <= i_byte.data_byte;
                6'd19:   r_width[15:8]    <= i_byte.data_byte;
                6'd20:   r_width[23:16]   <= i_byte.data_byte;
                6'd21:   r_width[31:24]   <= i_byte.data_byte;
                6'd22:   r_height[7:0]    <= i_byte.data_byte;
                6'd23:   r_height[15:8]   <= i_byte.data_byte;
                6'd24:   r_height[23:16]  <= i_byte.data_byte;
                6'd25:   r_height[31:24]  <= i_byte.data_byte;
                6'd28:   r_depth[7:0]     <= i_byte.data_byte;
                6'd29:   r_depth[15:8]    <= i_byte.data_byte;
                6'd30:   r_comp[7:0]      <= i_byte.data_byte;
                6'd31:   r_comp[15:8]     <= i_byte.data_byte;
                6'd32:   r_comp[23:16]    <= i_byte.data_byte;
                6'd33:   r_comp[31:24]    <= i_byte.data_byte;
                default: r_sig            <= r_sig;
            endcase
        end
    end

    // checks settle well before the last header byte
    always_ff @(posedge i_clk) begin
        r_hgt_abs    <= r_height[31] ? 32'(-r_height) : r_height;
        r_bottom_hdr <= !r_height[31] && (r_height != '0);
        if (r_sig != bmpd_pkg::BMP_SIGNATURE) begin
            r_chk_err <= bmpd_pkg::ERR_SIGNATURE;
        end else if ((r_depth != bmpd_pkg::DEPTH_24) && (r_depth != bmpd_pkg::DEPTH_32)) begin
            r_chk_err <= bmpd_pkg::ERR_DEPTH;
        end else if (r_comp != '0) begin
            r_chk_err <= bmpd_pkg::ERR_COMPRESSED;
        end else if ((r_width == '0) || (r_width > 32'(MAX_WIDTH)) ||
                     (r_hgt_abs == '0) || (r_hgt_abs > 32'(MAX_HEIGHT))) begin
            r_chk_err <= bmpd_pkg::ERR_DIMENSIONS;
        end else if (r_offset < bmpd_pkg::HEADER_LEN) begin
            r_chk_err <= bmpd_pkg::ERR_OFFSET;
        end else begin
            r_chk_err <= bmpd_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hdr) begin
            r_wid    <= r_width[WW-1:0];
            r_wid_m1 <= WW'(r_width[WW-1:0] - 1'b1);
            r_hgt_m1 <= HW'(r_hgt_abs[HW-1:0] - 1'b1);
            r_bottom <= r_bottom_hdr;
            r_is32   <= (r_depth == bmpd_pkg::DEPTH_32);
            // 24-bit rows pad by width mod 4 bytes
            r_pad    <= (r_depth == bmpd_pkg::DEPTH_32) ? 2'd0 : r_width[1:0];
        end
        if (color_wr) begin
            r_color[r_idx*8 +: 8] <= i_byte.data_byte;
        end
    end

endmodule

/* hdl/bmpd_queue.sv */
// bmpd_queue: short command queue between the parser and the output stage
// depends on bmpd_pkg and bmpd_if

module bmpd_queue #(
    parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH      = bmpd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmpd_cmd_if.sink   i_cmd,
    bmpd_cmd_if.source o_cmd
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = bmpd_pkg::KIND_W + bmpd_pkg::ERR_W + 2 * HW + 2 * WW
                        + bmpd_pkg::COLOR_W + 1;
    localparam int AW = $clog2(DEPTH);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [AW:0]   r_count;
    logic          push, pop;

    assign i_cmd.ready = (r_count != (AW + 1)'(DEPTH));
    assign o_cmd.valid = (r_count != '0);
    assign push        = i_cmd.valid & i_cmd.ready;
    assign pop         = o_cmd.valid & o_cmd.ready;

    assign {o_cmd.kind, o_cmd.err, o_cmd.dst_y, o_cmd.col, o_cmd.color,
            o_cmd.width, o_cmd.height, o_cmd.last} = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= {i_cmd.kind, i_cmd.err, i_cmd.dst_y, i_cmd.col, i_cmd.color,
                              i_cmd.width, i_cmd.height, i_cmd.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= AW'(r_wptr + 1'b1);
            end
            if (pop) begin
                r_rptr <= AW'(r_rptr + 1'b1);
            end
            priority if (push && !pop) begin
                r_count <= (AW + 1)'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= (AW + 1)'(r_count - 1'b1);
            end else begin
                r_count <= r_count;
            end
        end
    end

endmodule

/* hdl/bmpd_back.sv */
// bmpd_back: forms the destination address (row times width plus column)
// in a multiply stage and holds each result word in the output register
// depends on bmpd_pkg and bmpd_if

module bmpd_back #(
    parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmpd_cmd_if.sink      i_cmd,
    bmpd_result_if.source o_result
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = WW + HW;

    logic                         r_s1_valid;
    logic [PW-1:0]                r_s1_prod;
    logic [WW-1:0]                r_s1_col;
    logic [bmpd_pkg::KIND_W-1:0]  r_s1_kind;
    logic [bmpd_pkg::ERR_W-1:0]   r_s1_err;
    logic [bmpd_pkg::COLOR_W-1:0] r_s1_color;
    logic [WW-1:0]                r_s1_width;
    logic [HW-1:0]                r_s1_height;
    logic                         r_s1_last;

    logic                           r_o_valid;
    logic [bmpd_pkg::KIND_W-1:0]    r_o_kind;
    logic [bmpd_pkg::ERR_W-1:0]     r_o_err;
    logic [bmpd_pkg::ADDR_W-1:0]    r_o_addr;
    logic [bmpd_pkg::COLOR_W-1:0]   r_o_color;
    logic [bmpd_pkg::DIM_OUT_W-1:0] r_o_width;
    logic [bmpd_pkg::DIM_OUT_W-1:0] r_o_height;
    logic                           r_o_last;

    logic          s2_free;
    logic          s1_load;
    logic [PW-1:0] addr_sum;

    assign s2_free     = !r_o_valid || o_result.ready;
    assign s1_load     = !r_s1_valid || s2_free;
    assign i_cmd.ready = s1_load;
    assign addr_sum    = PW'(r_s1_prod + PW'(r_s1_col));

    assign o_result.valid         = r_o_valid;
    assign o_result.result_kind   = r_o_kind;
    assign o_result.error_code    = r_o_err;
    assign o_result.pixel_address = r_o_addr;
    assign o_result.pixel_color   = r_o_color;
    assign o_result.image_width   = r_o_width;
    assign o_result.image_height  = r_o_height;
    assign o_result.last_of_file  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (s2_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // non-pixel words carry zero row and column, so the address comes out zero
    always_ff @(posedge i_clk) begin
        if (s1_load && i_cmd.valid) begin
            r_s1_prod   <= PW'(i_cmd.dst_y * i_cmd.width);
            r_s1_col    <= i_cmd.col;
            r_s1_kind   <= i_cmd.kind;
            r_s1_err    <= i_cmd.err;
            r_s1_color  <= i_cmd.color;
            r_s1_width  <= i_cmd.width;
            r_s1_height <= i_cmd.height;
            r_s1_last   <= i_cmd.last;
        end
        if (s2_free && r_s1_valid) begin
            r_o_kind   <= r_s1_kind;
            r_o_err    <= r_s1_err;
            r_o_addr   <= bmpd_pkg::ADDR_W'(addr_sum);
            r_o_color  <= r_s1_color;
            r_o_width  <= bmpd_pkg::DIM_OUT_W'(r_s1_width);
            r_o_height <= bmpd_pkg::DIM_OUT_W'(r_s1_height);
            r_o_last   <= r_s1_last;
        end
    end

endmodule

/* hdl/bmp_pixel_stream_decoder.sv */
// bmp_pixel_stream_decoder: top level of the uncompressed 24/32 bpp bmp decoder
// depends on bmpd_pkg, bmpd_if, bmpd_front, bmpd_queue and bmpd_back
//
// usage:
//   i_byte takes the file one byte per word, in file order; first_byte marks
//   byte 0 of a new file and restarts parsing, last_byte marks the final byte.
//   o_result gives at most one word per input byte: header accepted (width and
//   absolute height), one pixel (0xRRGGBB and row * width + column, rows
//   flipped for bottom-up files), or an error code with last_of_file set.
//   throughput: one byte per cycle, sustained while the command queue has room.
//   path: the word that a byte causes is written into the command queue, then
//   passes the multiply stage and then the output register.
//   when o_result is stalled, words collect in the output register, the
//   multiply stage and a four-word command queue; i_byte.ready drops only
//   when that queue is full, so bytes that give no word keep flowing as long
//   as the queue has room.
//   reset clears the parser to the start of a file and empties the queue and
//   the output stages; no clearing pass is needed.

module bmp_pixel_stream_decoder #(
    parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmpd_byte_if.sink     i_byte,
    bmpd_result_if.source o_result
);

    bmpd_cmd_if #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) front_cmd ();
    bmpd_cmd_if #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) back_cmd ();

    bmpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_cmd   (front_cmd)
    );

    bmpd_queue #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (bmpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .o_cmd   (back_cmd)
    );

    bmpd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (back_cmd),
        .o_result (o_result)
    );

endmodule
